FILE: hdl/zbe_pkg.sv
// Shared constants and the term coefficient table for the Zernike basis evaluator.
// Depends on nothing; every other file imports it.
package zbe_pkg;

    localparam int ALL_TERMS       = 21;
    localparam int TERM_COUNT_DEF  = 21;
    localparam int FRAC_BITS_DEF   = 15;
    localparam int COORD_W         = 16;
    localparam int IDX_W           = 5;
    localparam int VAL_W           = 22;
    localparam int MONO_COUNT      = 21;
    localparam int MONO_IDX_W      = 5;
    localparam int COEF_W          = 6;
    localparam int SLOT_COUNT      = 6;
    localparam int SLOT_W          = 3;
    localparam int QDEPTH          = 2;

    typedef logic signed [COEF_W-1:0] coef_t;

    // One weighted monomial of a term: coefficient and which x^a y^b it uses.
    typedef struct packed {
        coef_t      coef;
        logic [2:0] ea;
        logic [2:0] eb;
    } slot_t;

    typedef slot_t [SLOT_COUNT-1:0] term_row_t;

    function automatic slot_t mk(input int c, input int a, input int b);
        slot_t s;
        s.coef = coef_t'(c);
        s.ea   = 3'(a);
        s.eb   = 3'(b);
        return s;
    endfunction

    // Unused slots carry a zero coefficient.
    function automatic term_row_t term_row(input logic [IDX_W-1:0] k);
        term_row_t r;
        for (int i = 0; i < SLOT_COUNT; i++) r[i] = mk(0, 0, 0);
        case (k)
            5'd0:  r[0] = mk(1, 0, 0);
            5'd1:  r[0] = mk(1, 1, 0);
            5'd2:  r[0] = mk(1, 0, 1);
            5'd3:  r[0] = mk(2, 1, 1);
            5'd4:  begin r[0] = mk(-1, 0, 0); r[1] = mk(2, 0, 2); r[2] = mk(2, 2, 0); end
            5'd5:  begin r[0] = mk(1, 0, 2); r[1] = mk(-1, 2, 0); end
            5'd6:  begin r[0] = mk(3, 1, 2); r[1] = mk(-1, 3, 0); end
            5'd7:  begin r[0] = mk(-2, 1, 0); r[1] = mk(3, 1, 2); r[2] = mk(3, 3, 0); end
            5'd8:  begin r[0] = mk(-2, 0, 1); r[1] = mk(3, 0, 3); r[2] = mk(3, 2, 1); end
            5'd9:  begin r[0] = mk(1, 0, 3); r[1] = mk(-3, 2, 1); end
            5'd10: begin r[0] = mk(4, 1, 3); r[1] = mk(-4, 3, 1); end
            5'd11: begin r[0] = mk(-6, 1, 1); r[1] = mk(8, 1, 3); r[2] = mk(8, 3, 1); end
            5'd12: begin
                r[0] = mk(1, 0, 0); r[1] = mk(-6, 0, 2); r[2] = mk(-6, 2, 0);
                r[3] = mk(6, 0, 4); r[4] = mk(12, 2, 2); r[5] = mk(6, 4, 0);
            end
            5'd13: begin
                r[0] = mk(-3, 0, 2); r[1] = mk(3, 2, 0);
                r[2] = mk(4, 0, 4);  r[3] = mk(-4, 4, 0);
            end
            5'd14: begin r[0] = mk(1, 0, 4); r[1] = mk(-6, 2, 2); r[2] = mk(1, 4, 0); end
            5'd15: begin r[0] = mk(5, 1, 4); r[1] = mk(-10, 3, 2); r[2] = mk(1, 5, 0); end
            5'd16: begin
                r[0] = mk(-12, 1, 2); r[1] = mk(4, 3, 0); r[2] = mk(15, 1, 4);
                r[3] = mk(10, 3, 2);  r[4] = mk(-5, 5, 0);
            end
            5'd17: begin
                r[0] = mk(3, 1, 0);  r[1] = mk(-12, 1, 2); r[2] = mk(-12, 3, 0);
                r[3] = mk(10, 1, 4); r[4] = mk(20, 3, 2);  r[5] = mk(10, 5, 0);
            end
            5'd18: begin
                r[0] = mk(3, 0, 1);  r[1] = mk(-12, 0, 3); r[2] = mk(-12, 2, 1);
                r[3] = mk(10, 0, 5); r[4] = mk(20, 2, 3);  r[5] = mk(10, 4, 1);
            end
            5'd19: begin
                r[0] = mk(-4, 0, 3); r[1] = mk(12, 2, 1); r[2] = mk(5, 0, 5);
                r[3] = mk(-10, 2, 3); r[4] = mk(-15, 4, 1);
            end
            5'd20: begin r[0] = mk(1, 0, 5); r[1] = mk(-10, 2, 3); r[2] = mk(5, 4, 1); end
            default: ;
        endcase
        return r;
    endfunction

endpackage

FILE: hdl/zbe_front.sv
// Front end: takes coordinate pairs and builds powers x^1..x^5, y^1..y^5 over five steps.
// Depends on zbe_pkg; feeds the power queue in zbe_queue.
module zbe_front
    import zbe_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int PW_W      = FRAC_BITS + 2
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COORD_W-1:0]    x_coord,
    input  logic signed [COORD_W-1:0]    y_coord,
    output logic                         pw_valid,
    input  logic                         pw_stall,
    output logic signed [5*PW_W-1:0]     px_all,
    output logic signed [5*PW_W-1:0]     py_all
);

    localparam int PROD_W = PW_W + COORD_W;

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [2:0]                 step_reg, step_next;
    logic signed [COORD_W-1:0]  xv_reg, yv_reg;
    logic signed [PW_W-1:0]     px_reg [1:5];
    logic signed [PW_W-1:0]     py_reg [1:5];
    logic signed [PW_W-1:0]     px_prev, py_prev;
    logic signed [PROD_W-1:0]   prod_x, prod_y;
    logic signed [PW_W-1:0]     rx, ry;
    logic                       in_acc;

    // Accept only when no pair is being built and no finished set waits.
    assign in_stall = busy_reg || done_reg;
    assign in_acc   = in_valid && !in_stall;
    assign pw_valid = done_reg;

    // One multiply per axis per step; previous power is one at step one.
    always_comb
    begin
        px_prev = (step_reg == 3'd1) ? PW_W'(1) <<< FRAC_BITS : px_reg[step_reg - 3'd1];
        py_prev = (step_reg == 3'd1) ? PW_W'(1) <<< FRAC_BITS : py_reg[step_reg - 3'd1];
        if (step_reg == 3'd0)
        begin
            px_prev = '0;
            py_prev = '0;
        end
        prod_x = PROD_W'(px_prev) * PROD_W'(xv_reg);
        prod_y = PROD_W'(py_prev) * PROD_W'(yv_reg);
        rx = PW_W'((prod_x + (PROD_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
        ry = PW_W'((prod_y + (PROD_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
    end

    // Sequence the five power steps, then hold the set until the queue takes it.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        step_next = step_reg;
        if (in_acc)
        begin
            busy_next = 1'b1;
            step_next = 3'd1;
        end
        else if (busy_reg)
        begin
            if (step_reg == 3'd5)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
                step_next = step_reg + 3'd1;
        end
        if (done_reg && !pw_stall)
            done_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Capture coordinates and powers.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            xv_reg <= x_coord;
            yv_reg <= y_coord;
        end
        if (busy_reg && step_reg != 3'd0)
        begin
            px_reg[step_reg] <= rx;
            py_reg[step_reg] <= ry;
        end
    end

    always_comb
    begin
        for (int i = 1; i <= 5; i++)
        begin
            px_all[(i-1)*PW_W +: PW_W] = px_reg[i];
            py_all[(i-1)*PW_W +: PW_W] = py_reg[i];
        end
    end

    property p_no_accept_busy;
        @(posedge clk) disable iff (!rst_n) busy_reg |-> !in_acc;
    endproperty
    assert property (p_no_accept_busy) else $error("front accepted while busy");

    property p_step_range;
        @(posedge clk) disable iff (!rst_n) busy_reg |-> (step_reg >= 3'd1 && step_reg <= 3'd5);
    endproperty
    assert property (p_step_range) else $error("front step out of range");

    property p_done_after_five;
        @(posedge clk) disable iff (!rst_n) $rose(done_reg) |-> $past(step_reg) == 3'd5;
    endproperty
    assert property (p_done_after_five) else $error("powers finished early");

endmodule

FILE: hdl/zbe_queue.sv
// Short queue of power sets between front and back end.
// Depends on zbe_pkg.
module zbe_queue
    import zbe_pkg::*;
#(
    parameter int W = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_valid,
    output logic         wr_stall,
    input  logic [W-1:0] wr_data,
    output logic         rd_valid,
    input  logic         rd_stall,
    output logic [W-1:0] rd_data
);

    logic [W-1:0] mem_reg [QDEPTH];
    logic         wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]   cnt_reg, cnt_next;
    logic         wr, rd;

    assign wr_stall = (cnt_reg == 2'(QDEPTH));
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign wr = wr_valid && !wr_stall;
    assign rd = rd_valid && !rd_stall;

    // Advance pointers and count.
    always_comb
    begin
        wp_next  = wr ? ~wp_reg : wp_reg;
        rp_next  = rd ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(wr) - 2'(rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wr_data;
    end

    property p_cnt_bound;
        @(posedge clk) disable iff (!rst_n) cnt_reg <= 2'(QDEPTH);
    endproperty
    assert property (p_cnt_bound) else $error("queue overfilled");

    property p_ptr_match;
        @(posedge clk) disable iff (!rst_n) (cnt_reg == 2'd0 || cnt_reg == 2'(QDEPTH)) |-> wp_reg == rp_reg;
    endproperty
    assert property (p_ptr_match) else $error("queue pointers disagree with count");

    property p_cnt_step;
        @(posedge clk) disable iff (!rst_n) (wr && !rd) |=> cnt_reg == $past(cnt_reg) + 2'd1;
    endproperty
    assert property (p_cnt_step) else $error("queue count did not advance");

endmodule

FILE: hdl/zbe_back.sv
// Back end: walks the terms, forms one monomial per slot, sums, saturates and emits.
// Depends on zbe_pkg; reads power sets from zbe_queue.
module zbe_back
    import zbe_pkg::*;
#(
    parameter int TERM_COUNT = TERM_COUNT_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int PW_W       = FRAC_BITS + 2
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      pw_valid,
    output logic                      pw_stall,
    input  logic signed [5*PW_W-1:0]  px_all,
    input  logic signed [5*PW_W-1:0]  py_all,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [IDX_W-1:0]          term_index,
    output logic signed [VAL_W-1:0]   term_value,
    output logic                      last_term
);

    localparam int CNT   = (TERM_COUNT > ALL_TERMS) ? ALL_TERMS :
                           ((TERM_COUNT < 1) ? 1 : TERM_COUNT);
    localparam int MP_W  = 2 * PW_W;
    localparam int MON_W = MP_W - FRAC_BITS + 1;
    localparam int SUM_W = MON_W + COEF_W + 4;

    // Stage 0: term counter over the head of the queue.
    logic [IDX_W-1:0] k_reg, k_next;
    logic             adv;
    logic             s1_valid_reg, s2_valid_reg, o_valid_reg;
    logic             s1_ready, s2_ready, o_ready;

    // Stage 1: monomial products.
    logic signed [MP_W-1:0]  s1_prod_reg [SLOT_COUNT];
    coef_t                   s1_coef_reg [SLOT_COUNT];
    logic [IDX_W-1:0]        s1_k_reg, s2_k_reg;
    // Stage 2: rounded monomials times coefficients.
    logic signed [SUM_W-1:0] s2_wt_reg [SLOT_COUNT];
    logic signed [SUM_W-1:0] sum;
    logic signed [VAL_W-1:0] sat;
    term_row_t               row;

    function automatic logic signed [PW_W-1:0] pw_sel(input logic signed [5*PW_W-1:0] all,
                                                      input logic [2:0] e);
        logic signed [PW_W-1:0] r;
        r = PW_W'(1) <<< FRAC_BITS;
        if (e != 3'd0)
            r = all[(e - 3'd1)*PW_W +: PW_W];
        return r;
    endfunction

    // Pipeline moves where each stage is empty or passes its word on.
    assign o_ready  = !o_valid_reg || !out_stall;
    assign s2_ready = !s2_valid_reg || o_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign adv      = pw_valid && s1_ready;
    assign pw_stall = !(adv && k_reg == IDX_W'(CNT - 1));

    assign row = term_row(k_reg);

    always_comb
    begin
        k_next = k_reg;
        if (adv)
            k_next = (k_reg == IDX_W'(CNT - 1)) ? '0 : k_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg        <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            k_reg <= k_next;
            if (s1_ready)
                s1_valid_reg <= adv;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (o_ready)
                o_valid_reg <= s2_valid_reg;
        end
    end

    // Sum the weighted monomials and clamp to the output range.
    always_comb
    begin
        sum = '0;
        for (int i = 0; i < SLOT_COUNT; i++)
            sum = sum + s2_wt_reg[i];
        if (sum > SUM_W'(2**(VAL_W-1) - 1))
            sat = {1'b0, {(VAL_W-1){1'b1}}};
        else if (sum < -SUM_W'(2**(VAL_W-1)))
            sat = {1'b1, {(VAL_W-1){1'b0}}};
        else
            sat = VAL_W'(sum);
    end

    always_ff @(posedge clk)
    begin
        if (adv && s1_ready)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                s1_prod_reg[i] <= MP_W'(pw_sel(px_all, row[i].ea)) *
                                  MP_W'(pw_sel(py_all, row[i].eb));
                s1_coef_reg[i] <= row[i].coef;
            end
            s1_k_reg <= k_reg;
        end
        if (s1_valid_reg && s2_ready)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
                s2_wt_reg[i] <= SUM_W'((s1_prod_reg[i] + (MP_W'(1) <<< (FRAC_BITS - 1)))
                                        >>> FRAC_BITS) * SUM_W'(s1_coef_reg[i]);
            s2_k_reg <= s1_k_reg;
        end
        if (s2_valid_reg && o_ready)
        begin
            term_value <= sat;
            term_index <= s2_k_reg;
            last_term  <= (s2_k_reg == IDX_W'(CNT - 1));
        end
    end

    assign out_valid = o_valid_reg;

    property p_k_bound;
        @(posedge clk) disable iff (!rst_n) k_reg <= IDX_W'(CNT - 1);
    endproperty
    assert property (p_k_bound) else $error("term counter out of range");

    property p_pop_on_last;
        @(posedge clk) disable iff (!rst_n) !pw_stall |-> (pw_valid && k_reg == IDX_W'(CNT - 1));
    endproperty
    assert property (p_pop_on_last) else $error("power set released before last term");

    property p_out_hold;
        @(posedge clk) disable iff (!rst_n) (out_valid && out_stall) |=> out_valid;
    endproperty
    assert property (p_out_hold) else $error("result dropped while stalled");

endmodule

FILE: hdl/zernike_basis_evaluator.sv
// Top level of the Zernike basis evaluator: front power builder, queue and term back end.
// Depends on zbe_pkg, zbe_front, zbe_queue and zbe_back.
//
// Each accepted (x, y) pair in Q1.15 yields TERM_COUNT results in term order, one per
// cycle while the receiver does not stall and a power set waits, the last flagged by
// last_term. The front end builds the powers in five multiply steps while the back end
// is still emitting the previous pair, and a two-entry queue holds finished power sets.
module zernike_basis_evaluator
    import zbe_pkg::*;
#(
    parameter int TERM_COUNT = TERM_COUNT_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [COORD_W-1:0] x_coord,
    input  logic signed [COORD_W-1:0] y_coord,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [IDX_W-1:0]          term_index,
    output logic signed [VAL_W-1:0]   term_value,
    output logic                      last_term
);

    localparam int PW_W = FRAC_BITS + 2;

    logic                     f_valid, f_stall, q_valid, q_stall;
    logic signed [5*PW_W-1:0] f_px, f_py, q_px, q_py;

    zbe_front #(.FRAC_BITS(FRAC_BITS), .PW_W(PW_W)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .x_coord(x_coord), .y_coord(y_coord),
        .pw_valid(f_valid), .pw_stall(f_stall),
        .px_all(f_px), .py_all(f_py)
    );

    zbe_queue #(.W(10*PW_W)) u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_stall(f_stall), .wr_data({f_px, f_py}),
        .rd_valid(q_valid), .rd_stall(q_stall), .rd_data({q_px, q_py})
    );

    zbe_back #(.TERM_COUNT(TERM_COUNT), .FRAC_BITS(FRAC_BITS), .PW_W(PW_W)) u_back (
        .clk(clk), .rst_n(rst_n),
        .pw_valid(q_valid), .pw_stall(q_stall),
        .px_all(q_px), .py_all(q_py),
        .out_valid(out_valid), .out_stall(out_stall),
        .term_index(term_index), .term_value(term_value), .last_term(last_term)
    );

endmodule

FILE: verif/tb.sv
// Self-checking bench for zernike_basis_evaluator: directed coordinate table, then random pairs.
// Depends on zbe_pkg and the evaluator RTL; predicts every basis term from shared powers.
module tb;
    import zbe_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC   = FRAC_BITS_DEF;
    localparam int NTERMS = TERM_COUNT_DEF;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam longint VMAX = 2097151;
    localparam longint VMIN = -2097152;

    typedef struct {
        logic [IDX_W-1:0]        idx;
        logic signed [VAL_W-1:0] val;
        logic                    last;
    } basis_word_t;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      has_fixed;
        longint                    piston;
    } coord_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [COORD_W-1:0] x_coord = '0;
    logic signed [COORD_W-1:0] y_coord = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [IDX_W-1:0] term_index;
    logic signed [VAL_W-1:0] term_value;
    logic last_term;

    basis_word_t pending_terms[$];
    int  mismatch_count = 0;
    int  idle_cycles = 0;
    int  send_gap_pct = 0;
    int  recv_stall_pct = 0;
    bit  timed_out = 0;
    coord_row_t directed[$];

    zernike_basis_evaluator u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .x_coord(x_coord), .y_coord(y_coord),
        .out_valid(out_valid), .out_stall(out_stall),
        .term_index(term_index), .term_value(term_value), .last_term(last_term)
    );

    always #1 clk = ~clk;

    // Round to nearest, ties up, dropping FRAC fraction bits.
    function automatic longint round_frac(input longint v);
        return (v + (longint'(1) << (FRAC - 1))) >>> FRAC;
    endfunction

    // Build the power table and push all expected basis words for one pair.
    function automatic void predict_basis(input logic signed [COORD_W-1:0] xv,
                                          input logic signed [COORD_W-1:0] yv);
        longint px[6];
        longint py[6];
        longint sum;
        term_row_t row;
        basis_word_t w;
        px[0] = longint'(1) << FRAC;
        py[0] = longint'(1) << FRAC;
        for (int k = 1; k < 6; k++) begin
            px[k] = round_frac(px[k-1] * longint'(xv));
            py[k] = round_frac(py[k-1] * longint'(yv));
        end
        for (int k = 0; k < NTERMS; k++) begin
            row = term_row(IDX_W'(k));
            sum = 0;
            for (int s = 0; s < SLOT_COUNT; s++)
                sum += longint'(row[s].coef) * round_frac(px[row[s].ea] * py[row[s].eb]);
            if (sum > VMAX) sum = VMAX;
            if (sum < VMIN) sum = VMIN;
            w.idx  = IDX_W'(k);
            w.val  = VAL_W'(sum);
            w.last = (k == NTERMS - 1);
            pending_terms.push_back(w);
        end
    endfunction

    // Present one pair at the falling edge and hold it until accepted.
    task automatic send_pair(input logic signed [COORD_W-1:0] xv,
                             input logic signed [COORD_W-1:0] yv);
        while ($urandom_range(99) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        x_coord  <= xv;
        y_coord  <= yv;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    // Receiver stall pattern, changed at the falling edge.
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    // Check each accepted basis word against the oldest expectation.
    always @(posedge clk) begin
        basis_word_t e;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_terms.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected word: idx %0d val %0d last %0b",
                             term_index, term_value, last_term);
            end else begin
                e = pending_terms.pop_front();
                if (e.idx !== term_index || e.val !== term_value || e.last !== last_term) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp idx %0d val %0d last %0b, got %0d %0d %0b",
                                 e.idx, e.val, e.last, term_index, term_value, last_term);
                end
            end
        end
    end

    // Watchdog on cycles with no accepted word on either side.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic coord_row_t row_of(input int xv, input int yv,
                                          input bit fixed, input longint pist);
        coord_row_t r;
        r.x = COORD_W'(xv);
        r.y = COORD_W'(yv);
        r.has_fixed = fixed;
        r.piston = pist;
        return r;
    endfunction

    initial begin
        int phase_items;
        // Directed table: origin, unit extremes, minus one, mixed signs, saturation corners.
        directed.push_back(row_of(0, 0, 1, 32768));
        directed.push_back(row_of(32767, 0, 0, 0));
        directed.push_back(row_of(-32768, 0, 1, 32768));
        directed.push_back(row_of(0, -32768, 1, 32768));
        directed.push_back(row_of(0, 32767, 0, 0));
        directed.push_back(row_of(-32768, -32768, 1, 32768));
        directed.push_back(row_of(32767, 32767, 0, 0));
        directed.push_back(row_of(-32768, 32767, 0, 0));
        directed.push_back(row_of(32767, -32768, 0, 0));
        directed.push_back(row_of(16384, 16384, 0, 0));
        directed.push_back(row_of(-16384, 16384, 0, 0));
        directed.push_back(row_of(1, -1, 0, 0));
        directed.push_back(row_of(-1, 1, 0, 0));
        directed.push_back(row_of(23170, 23170, 0, 0));
        directed.push_back(row_of(-23170, -23170, 0, 0));
        directed.push_back(row_of(21845, -10923, 0, 0));

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Walk the directed table; pinned piston rows also check the known value.
        foreach (directed[i]) begin
            predict_basis(directed[i].x, directed[i].y);
            if (directed[i].has_fixed &&
                pending_terms[pending_terms.size() - NTERMS].val != VAL_W'(directed[i].piston)) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("piston mismatch on row %0d: exp %0d got %0d", i,
                             directed[i].piston,
                             pending_terms[pending_terms.size() - NTERMS].val);
            end
            send_pair(directed[i].x, directed[i].y);
        end

        // Random pairs in three idling phases; mostly in-pupil, some full range.
        for (int phase = 0; phase < 3; phase++) begin
            send_gap_pct   = (phase == 0) ? 11 : (phase == 1) ? 68 : 0;
            recv_stall_pct = (phase == 0) ? 68 : (phase == 1) ? 11 : 0;
            phase_items = 130;
            for (int n = 0; n < phase_items; n++) begin
                logic signed [COORD_W-1:0] rx;
                logic signed [COORD_W-1:0] ry;
                if ($urandom_range(3) == 0) begin
                    rx = COORD_W'($urandom);
                    ry = COORD_W'($urandom);
                end else begin
                    rx = COORD_W'(int'($urandom_range(46340)) - 23170);
                    ry = COORD_W'(int'($urandom_range(46340)) - 23170);
                end
                predict_basis(rx, ry);
                send_pair(rx, ry);
            end
        end
        in_valid <= 1'b0;

        // Drain, then allow the pipeline latency to settle.
        while (pending_terms.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
